@@ rtl/addressed_lamp_command_receiver_macros.svh @@
// Assertion macros shared by the lamp command receiver RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ADDRESSED_LAMP_COMMAND_RECEIVER_MACROS_SVH
`define ADDRESSED_LAMP_COMMAND_RECEIVER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ALCR_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ALCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/alcr_pkg.sv @@
// Shared types and constants for the addressed lamp command receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package alcr_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 8;

   localparam logic [7:0] BROADCAST_ADDRESS  = 8'h00;
   localparam logic [7:0] OWN_ADDRESS_RESET  = 8'h01;

   localparam logic [7:0] OP_SOFT_RESET = 8'h01;
   localparam logic [7:0] OP_SET_COLOUR = 8'h02;
   localparam logic [7:0] OP_FADE       = 8'h03;

   localparam int LEN_SET_COLOUR = 4;
   localparam int LEN_FADE       = 6;
   localparam int CMD_ARGS       = LEN_FADE - 1;

   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_SOFT_RESET = 2'd0,
      CMD_SET_COLOUR = 2'd1,
      CMD_FADE       = 2'd2
   } command_kind_type;

   // Decoded command: kind plus the buffered argument bytes (byte 1 onward).
   typedef struct packed {
      command_kind_type               kind;
      logic [CMD_ARGS-1:0][7:0]       arg;
   } cmd_rec_type;

endpackage

`default_nettype wire

@@ rtl/addressed_lamp_command_receiver.sv @@
// Addressed lamp command receiver. Takes one 9-bit bus frame per clock when
// req_full is low; a frame is filtered, buffered and decoded in the cycle it
// is taken, and a completed command is queued and registered onto the rsp_
// ports. Throughput is one frame per cycle for as long as results are popped;
// req_full is raised only while the two-entry command queue holds two commands
// not yet moved to the output register. Frames that complete no command never
// wait on the result side beyond that. The own address is written through csr_,
// which is always ready; write it only while no frame is in flight.
// Depends on alcr_pkg, alcr_front, alcr_cmd_queue and alcr_back.
`default_nettype none

module addressed_lamp_command_receiver
   import alcr_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_ninth_bit,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_command_kind,
   output logic [7:0]       rsp_speed_high,
   output logic [7:0]       rsp_speed_low,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_own_address
);

   cmd_rec_type front_rec;
   logic        front_rec_valid;
   logic        q_full;
   cmd_rec_type head_rec;
   logic        q_empty;
   logic        q_pop;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   alcr_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push_i            (req_push),
      .full_i            (q_full),
      .frame_byte_i      (req_frame_byte),
      .ninth_bit_i       (req_ninth_bit),
      .csr_valid_i       (csr_valid && csr_ready),
      .csr_own_address_i (csr_own_address),
      .rec_o             (front_rec),
      .rec_valid_o       (front_rec_valid)
   );

   alcr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (front_rec_valid),
      .push_rec_i (front_rec),
      .full_o     (q_full),
      .pop_i      (q_pop),
      .head_rec_o (head_rec),
      .empty_o    (q_empty)
   );

   alcr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_rec_i         (head_rec),
      .q_empty_i          (q_empty),
      .q_pop_o            (q_pop),
      .rsp_empty_o        (rsp_empty),
      .rsp_pop_i          (rsp_pop),
      .rsp_command_kind_o (rsp_command_kind),
      .rsp_speed_high_o   (rsp_speed_high),
      .rsp_speed_low_o    (rsp_speed_low),
      .rsp_red_o          (rsp_red),
      .rsp_green_o        (rsp_green),
      .rsp_blue_o         (rsp_blue)
   );

endmodule

`default_nettype wire

@@ rtl/alcr_front.sv @@
// Front end: address filtering, mute state, byte buffer and command decode.
// Uses alcr_pkg and the shared assertion macros.
`default_nettype none
`include "addressed_lamp_command_receiver_macros.svh"

module alcr_front
   import alcr_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_i,
   input  wire logic        full_i,
   input  wire logic [7:0]  frame_byte_i,
   input  wire logic        ninth_bit_i,
   input  wire logic        csr_valid_i,
   input  wire logic [7:0]  csr_own_address_i,
   output cmd_rec_type      rec_o,
   output logic             rec_valid_o
);

   localparam int COUNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int IDX_W   = $clog2(BUFFER_DEPTH);

   logic [7:0]          own_address_ff;
   logic                muted_ff, muted_in;
   logic [COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]          cmd_bytes_ff [BUFFER_DEPTH];

   logic                accept;
   logic                room;
   logic                buf_wr;
   logic [COUNT_W-1:0]  count_next;
   logic [LEN_FADE-1:0][7:0] view;
   logic [7:0]          op;

   assign accept     = push_i && !full_i;
   assign room       = byte_count_ff < COUNT_W'(BUFFER_DEPTH);
   assign buf_wr     = accept && !ninth_bit_i && !muted_ff && room;
   assign count_next = room ? byte_count_ff + COUNT_W'(1) : byte_count_ff;

   // Buffer contents as they stand after this byte is written.
   always_comb begin
      for (int i = 0; i < LEN_FADE; i++) begin
         view[i] = (room && byte_count_ff == COUNT_W'(i)) ? frame_byte_i : cmd_bytes_ff[i];
      end
   end

   assign op = view[0];

   always_comb begin
      muted_in      = muted_ff;
      byte_count_in = byte_count_ff;
      rec_valid_o   = 1'b0;
      rec_o.kind    = CMD_SOFT_RESET;
      rec_o.arg     = view[LEN_FADE-1:1];
      if (accept) begin
         if (ninth_bit_i) begin
            if (frame_byte_i == BROADCAST_ADDRESS || frame_byte_i == own_address_ff) begin
               muted_in      = 1'b0;
               byte_count_in = '0;
            end else begin
               muted_in = 1'b1;
            end
         end else if (!muted_ff) begin
            byte_count_in = count_next;
            priority if (op == OP_SOFT_RESET) begin
               rec_valid_o = 1'b1;
               rec_o.kind  = CMD_SOFT_RESET;
            end else if (op == OP_SET_COLOUR && count_next == COUNT_W'(LEN_SET_COLOUR)) begin
               rec_valid_o = 1'b1;
               rec_o.kind  = CMD_SET_COLOUR;
               muted_in    = 1'b1;
            end else if (op == OP_FADE && count_next == COUNT_W'(LEN_FADE)) begin
               rec_valid_o = 1'b1;
               rec_o.kind  = CMD_FADE;
               muted_in    = 1'b1;
            end else begin
               rec_valid_o = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= OWN_ADDRESS_RESET;
         muted_ff       <= 1'b1;
         byte_count_ff  <= '0;
      end else begin
         if (csr_valid_i) begin
            own_address_ff <= csr_own_address_i;
         end
         muted_ff      <= muted_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_wr) begin
         cmd_bytes_ff[byte_count_ff[IDX_W-1:0]] <= frame_byte_i;
      end
   end

   `ALCR_ASSERT_HOLDS(a_count_bound, clock, reset,
      byte_count_ff <= COUNT_W'(BUFFER_DEPTH), "byte count past buffer depth")
   `ALCR_ASSERT_NEXT(a_mute_after_colour, clock, reset,
      rec_valid_o && rec_o.kind != CMD_SOFT_RESET, muted_ff,
      "not muted after colour command")
   `ALCR_ASSERT_NEXT(a_address_unmutes, clock, reset,
      accept && ninth_bit_i && frame_byte_i == BROADCAST_ADDRESS,
      !muted_ff && byte_count_ff == '0, "broadcast did not unmute")

endmodule

`default_nettype wire

@@ rtl/alcr_cmd_queue.sv @@
// Two-entry queue of decoded commands between front end and result stage.
// Uses alcr_pkg and the shared assertion macros.
`default_nettype none
`include "addressed_lamp_command_receiver_macros.svh"

module alcr_cmd_queue
   import alcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_i,
   input  wire cmd_rec_type push_rec_i,
   output logic             full_o,
   input  wire logic        pop_i,
   output cmd_rec_type      head_rec_o,
   output logic             empty_o
);

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_rec_type         entries_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full_o     = count_ff == CNT_W'(CMD_QUEUE_DEPTH);
   assign empty_o    = count_ff == '0;
   assign head_rec_o = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push_i, pop_i})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entries_ff[wr_ptr_ff] <= push_rec_i;
      end
   end

   `ALCR_ASSERT_HOLDS(a_no_overflow, clock, reset,
      !push_i || !full_o, "push into full command queue")
   `ALCR_ASSERT_HOLDS(a_no_underflow, clock, reset,
      !pop_i || !empty_o, "pop from empty command queue")

endmodule

`default_nettype wire

@@ rtl/alcr_back.sv @@
// Result stage: pulls decoded commands and formats them into the output register.
// Uses alcr_pkg.
`default_nettype none

module alcr_back
   import alcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_rec_type head_rec_i,
   input  wire logic        q_empty_i,
   output logic             q_pop_o,
   output logic             rsp_empty_o,
   input  wire logic        rsp_pop_i,
   output logic [1:0]       rsp_command_kind_o,
   output logic [7:0]       rsp_speed_high_o,
   output logic [7:0]       rsp_speed_low_o,
   output logic [7:0]       rsp_red_o,
   output logic [7:0]       rsp_green_o,
   output logic [7:0]       rsp_blue_o
);

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  speed_high_ff, speed_high_in;
   logic [7:0]  speed_low_ff, speed_low_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;

   // Refill whenever the output slot is free or its transfer completes now.
   assign q_pop_o = !q_empty_i && (!out_valid_ff || rsp_pop_i);

   always_comb begin
      out_valid_in  = q_pop_o ? 1'b1 : (out_valid_ff && !rsp_pop_i);
      kind_in       = head_rec_i.kind;
      speed_high_in = '0;
      speed_low_in  = '0;
      red_in        = '0;
      green_in      = '0;
      blue_in       = '0;
      unique case (head_rec_i.kind)
         CMD_SET_COLOUR: begin
            red_in   = head_rec_i.arg[0];
            green_in = head_rec_i.arg[1];
            blue_in  = head_rec_i.arg[2];
         end
         CMD_FADE: begin
            speed_high_in = head_rec_i.arg[0];
            speed_low_in  = head_rec_i.arg[1];
            red_in        = head_rec_i.arg[2];
            green_in      = head_rec_i.arg[3];
            blue_in       = head_rec_i.arg[4];
         end
         default: begin
            kind_in = CMD_SOFT_RESET;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop_o) begin
         kind_ff       <= kind_in;
         speed_high_ff <= speed_high_in;
         speed_low_ff  <= speed_low_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
      end
   end

   assign rsp_empty_o        = !out_valid_ff;
   assign rsp_command_kind_o = kind_ff;
   assign rsp_speed_high_o   = speed_high_ff;
   assign rsp_speed_low_o    = speed_low_ff;
   assign rsp_red_o          = red_ff;
   assign rsp_green_o        = green_ff;
   assign rsp_blue_o         = blue_ff;

endmodule

`default_nettype wire
